// ===== sv/universal_oscillator_defines.svh =====
`ifndef UNIVERSAL_OSCILLATOR_DEFINES_SVH
`define UNIVERSAL_OSCILLATOR_DEFINES_SVH

// same-cycle implication
`define UO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uo_pkg.sv =====
package uo_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int OUT_WIDTH    = 16;
    localparam int FILT_WIDTH   = SAMPLE_WIDTH + 8;
    localparam int SUM_WIDTH    = SAMPLE_WIDTH + 1;
    localparam int COEF_WIDTH   = 32;
    localparam int FRAC_BITS    = 30;
    localparam int OPND_WIDTH   = FILT_WIDTH + 1;
    localparam int DIGIT_WIDTH  = 16;
    localparam int NUM_DIGITS   = (OPND_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int EXT_WIDTH    = NUM_DIGITS * DIGIT_WIDTH;
    localparam int DIGIT_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PROD_WIDTH   = COEF_WIDTH + DIGIT_WIDTH + 1;
    localparam int ACC_WIDTH    = COEF_WIDTH + OPND_WIDTH + 3;
    localparam int NUM_TERMS    = 3;
    localparam int TERM_IDX_W   = $clog2(NUM_TERMS);
    localparam int REM_WIDTH    = FILT_WIDTH + 1;
    localparam int QUO_WIDTH    = OUT_WIDTH + 1;
    localparam int DIV_CNT_W    = $clog2(OUT_WIDTH + 1);
    localparam int COUNT_W      = 2;
    localparam int CFG_IDX_W    = 2;

    localparam logic [DIGIT_IDX_W-1:0] DIGIT_LAST = DIGIT_IDX_W'(NUM_DIGITS - 1);

    localparam logic [TERM_IDX_W-1:0] TERM_INPUT = TERM_IDX_W'(0);
    localparam logic [TERM_IDX_W-1:0] TERM_PREV1 = TERM_IDX_W'(1);
    localparam logic [TERM_IDX_W-1:0] TERM_PREV2 = TERM_IDX_W'(2);
    localparam logic [TERM_IDX_W-1:0] TERM_LAST  = TERM_IDX_W'(NUM_TERMS - 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(3);

    localparam logic signed [COEF_WIDTH-1:0] COEF_INPUT_RST = COEF_WIDTH'(84934000);
    localparam logic signed [COEF_WIDTH-1:0] COEF_PREV1_RST = COEF_WIDTH'(1677395000);
    localparam logic signed [COEF_WIDTH-1:0] COEF_PREV2_RST = COEF_WIDTH'(-688590000);
    localparam logic signed [COEF_WIDTH-1:0] DECAY_Q30      = COEF_WIDTH'(1064078148);

    localparam logic signed [ACC_WIDTH-1:0] ACC_ONE      = ACC_WIDTH'(1);
    localparam logic signed [ACC_WIDTH-1:0] ROUND_FILT   = ACC_ONE <<< FRAC_BITS;
    localparam logic signed [ACC_WIDTH-1:0] ROUND_PEAK   = ACC_ONE <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_WIDTH-1:0] FILT_MAX_ACC =
        (ACC_ONE <<< (FILT_WIDTH - 1)) - ACC_ONE;

    localparam logic [FILT_WIDTH-1:0] PEAK_ONE    = FILT_WIDTH'(1);
    localparam logic [OUT_WIDTH-1:0]  OUT_POS_MAX = {1'b0, {(OUT_WIDTH - 1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_INPUT = 2'd0,
        CFG_COEF_PREV1 = 2'd1,
        CFG_COEF_PREV2 = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT_MAC,
        S_FILT_DRAIN,
        S_FILT_DONE,
        S_PEAK_MAC,
        S_PEAK_DRAIN,
        S_PEAK_DONE,
        S_DIV,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic                         issue;
        logic                         clear;
        logic                         round_filt;
        logic [DIGIT_IDX_W-1:0]       digit;
        logic signed [COEF_WIDTH-1:0] coef;
        logic signed [OPND_WIDTH-1:0] operand;
    } t_mac_req;

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [FILT_WIDTH-1:0] dividend;
        logic [FILT_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [OUT_WIDTH-1:0] result;
    } t_div_stat;

endpackage

// ===== sv/uo_in_if.sv =====
interface uo_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [uo_pkg::SAMPLE_WIDTH-1:0]  price;
    logic                                    series_start;

    modport source (output valid, output price, output series_start, input ready);
    modport sink (input valid, input price, input series_start, output ready);
endinterface

// ===== sv/uo_out_if.sv =====
interface uo_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [uo_pkg::OUT_WIDTH-1:0]  oscillator;

    modport source (output valid, output oscillator, input ready);
    modport sink (input valid, input oscillator, output ready);
endinterface

// ===== sv/uo_mac.sv =====
`include "universal_oscillator_defines.svh"

module uo_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  uo_pkg::t_mac_req                       i_req,
    output logic signed [uo_pkg::ACC_WIDTH-1:0]    o_acc
);

    logic signed [uo_pkg::EXT_WIDTH-1:0]   w_ext;
    logic [uo_pkg::DIGIT_WIDTH-1:0]        w_raw;
    logic signed [uo_pkg::DIGIT_WIDTH:0]   w_digit;
    logic signed [uo_pkg::ACC_WIDTH-1:0]   w_term;

    logic signed [uo_pkg::PROD_WIDTH-1:0]  r_prod;
    logic                                  r_prod_valid;
    logic [uo_pkg::DIGIT_IDX_W-1:0]        r_shift;
    logic signed [uo_pkg::ACC_WIDTH-1:0]   r_acc;

    // one 16-bit digit of the operand per pass, top digit signed
    always_comb begin
        w_ext = uo_pkg::EXT_WIDTH'($signed(i_req.operand));
        w_raw = w_ext[i_req.digit * uo_pkg::DIGIT_WIDTH +: uo_pkg::DIGIT_WIDTH];
        if (i_req.digit == uo_pkg::DIGIT_LAST) begin
            w_digit = $signed({w_raw[uo_pkg::DIGIT_WIDTH-1], w_raw});
        end else begin
            w_digit = $signed({1'b0, w_raw});
        end
        w_term = uo_pkg::ACC_WIDTH'(r_prod) <<< (r_shift * uo_pkg::DIGIT_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_req.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= i_req.coef * w_digit;
        r_shift <= i_req.digit;
        if (i_req.clear) begin
            r_acc <= i_req.round_filt ? uo_pkg::ROUND_FILT : uo_pkg::ROUND_PEAK;
        end else if (r_prod_valid) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_acc = r_acc;

    `UO_ASSERT_NOW(a_clear_no_pending, i_clk, i_rst_n, i_req.clear, !r_prod_valid, "accumulator cleared with a product in flight")

endmodule

// ===== sv/uo_div.sv =====
`include "universal_oscillator_defines.svh"

module uo_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uo_pkg::t_div_req   i_req,
    output uo_pkg::t_div_stat  o_stat
);

    logic                               r_busy;
    logic                               r_done;
    logic [uo_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [uo_pkg::REM_WIDTH-1:0]       r_rem;
    logic [uo_pkg::FILT_WIDTH-1:0]      r_dvs;
    logic [uo_pkg::QUO_WIDTH-1:0]       r_quo;
    logic                               r_neg;

    logic                               w_first;
    logic                               w_last;
    logic                               w_ge;
    logic [uo_pkg::REM_WIDTH-1:0]       w_trial;
    logic [uo_pkg::REM_WIDTH-1:0]       w_rem_next;
    logic [uo_pkg::QUO_WIDTH-1:0]       w_quo_inc;
    logic [uo_pkg::OUT_WIDTH-1:0]       w_mag;

    always_comb begin
        w_first    = (r_cnt == '0);
        w_last     = (r_cnt == uo_pkg::DIV_CNT_W'(uo_pkg::OUT_WIDTH));
        w_trial    = w_first ? r_rem : (r_rem << 1);
        w_ge       = (w_trial >= {1'b0, r_dvs});
        w_rem_next = w_ge ? (w_trial - {1'b0, r_dvs}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + uo_pkg::DIV_CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.dividend};
            r_dvs <= i_req.divisor;
            r_quo <= '0;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[uo_pkg::QUO_WIDTH-2:0], w_ge};
        end
    end

    // round half away from zero on the magnitude, clip +1 to the largest code
    always_comb begin
        w_quo_inc     = r_quo + uo_pkg::QUO_WIDTH'(1);
        w_mag         = w_quo_inc[uo_pkg::QUO_WIDTH-1:1];
        o_stat.busy   = r_busy;
        o_stat.done   = r_done;
        if (r_neg) begin
            o_stat.result = -w_mag;
        end else if (w_mag > uo_pkg::OUT_POS_MAX) begin
            o_stat.result = uo_pkg::OUT_POS_MAX;
        end else begin
            o_stat.result = w_mag;
        end
    end

    `UO_ASSERT_NOW(a_rem_below_dvs, i_clk, i_rst_n, (r_busy && (r_cnt != '0)), (r_rem < {1'b0, r_dvs}), "partial remainder not below divisor")
    `UO_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "divider done held over two cycles")

endmodule

// ===== sv/universal_oscillator.sv =====
// an accepted word passes the filter, the peak and the divider before its result
//   word is valid, the first sample of a series skipping filter and peak; a new word
//   is taken only in idle, after the last result is loaded; a full word takes 12
//   passes of the shared 32x17 multiplier and 17 steps of the bit-serial divider
// reset: synchronous active low, restores coefficient defaults and clears history
`include "universal_oscillator_defines.svh"

module universal_oscillator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [uo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uo_pkg::COEF_WIDTH-1:0]     i_cfg_data,
    uo_in_if.sink                             i_in,
    uo_out_if.source                          o_out
);

    uo_pkg::t_state                          r_state, n_state;

    logic signed [uo_pkg::COEF_WIDTH-1:0]    r_coef_input, r_coef_prev1, r_coef_prev2;
    logic signed [uo_pkg::SAMPLE_WIDTH-1:0]  r_price_prev1, r_price_prev2, r_noise_prev;
    logic signed [uo_pkg::FILT_WIDTH-1:0]    r_filt_prev1, r_filt_prev2;
    logic [uo_pkg::FILT_WIDTH-1:0]           r_peak;
    logic [uo_pkg::COUNT_W-1:0]              r_count;
    logic [uo_pkg::TERM_IDX_W-1:0]           r_term;
    logic [uo_pkg::DIGIT_IDX_W-1:0]          r_digit;
    logic signed [uo_pkg::SUM_WIDTH-1:0]     r_sum;
    logic [uo_pkg::FILT_WIDTH-1:0]           r_mag;
    logic                                    r_neg;
    logic                                    r_out_valid;
    logic signed [uo_pkg::OUT_WIDTH-1:0]     r_out_data;

    logic                                    w_in_ready;
    logic                                    w_accept;
    logic [uo_pkg::COUNT_W-1:0]              w_idx;
    logic signed [uo_pkg::SUM_WIDTH-1:0]     w_diff;
    logic signed [uo_pkg::SAMPLE_WIDTH-1:0]  w_noise;
    logic signed [uo_pkg::SUM_WIDTH-1:0]     w_sum;
    logic                                    w_filt_last;
    logic                                    w_peak_last;
    logic signed [uo_pkg::ACC_WIDTH-1:0]     w_acc;
    logic signed [uo_pkg::ACC_WIDTH-1:0]     w_filt_wide;
    logic signed [uo_pkg::ACC_WIDTH-1:0]     w_filt_clip;
    logic signed [uo_pkg::FILT_WIDTH-1:0]    w_filt;
    logic [uo_pkg::FILT_WIDTH-1:0]           w_filt_mag;
    logic signed [uo_pkg::ACC_WIDTH-1:0]     w_peak_wide;
    logic [uo_pkg::FILT_WIDTH-1:0]           w_peak_dec;
    logic [uo_pkg::FILT_WIDTH-1:0]           w_peak_new;
    logic                                    w_out_load;
    uo_pkg::t_mac_req                        w_mac_req;
    uo_pkg::t_div_req                        w_div_req;
    uo_pkg::t_div_stat                       w_div_stat;

    uo_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .o_acc   (w_acc)
    );

    uo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    assign w_in_ready       = (r_state == uo_pkg::S_IDLE);
    assign w_accept         = i_in.valid && w_in_ready;
    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.oscillator = r_out_data;

    // input pair for the filter
    always_comb begin
        w_idx   = i_in.series_start ? '0 : r_count;
        w_diff  = uo_pkg::SUM_WIDTH'(i_in.price) - uo_pkg::SUM_WIDTH'(r_price_prev2);
        w_noise = uo_pkg::SAMPLE_WIDTH'(w_diff >>> 1);
        if (w_idx != uo_pkg::COUNT_MAX) begin
            w_sum = uo_pkg::SUM_WIDTH'(i_in.price) + uo_pkg::SUM_WIDTH'(r_price_prev1);
        end else begin
            w_sum = uo_pkg::SUM_WIDTH'(w_noise) + uo_pkg::SUM_WIDTH'(r_noise_prev);
        end
    end

    // filter round and clip, peak decay and floor
    always_comb begin
        w_filt_wide = w_acc >>> (uo_pkg::FRAC_BITS + 1);
        if (w_filt_wide > uo_pkg::FILT_MAX_ACC) begin
            w_filt_clip = uo_pkg::FILT_MAX_ACC;
        end else if (w_filt_wide < -uo_pkg::FILT_MAX_ACC) begin
            w_filt_clip = -uo_pkg::FILT_MAX_ACC;
        end else begin
            w_filt_clip = w_filt_wide;
        end
        w_filt     = w_filt_clip[uo_pkg::FILT_WIDTH-1:0];
        w_filt_mag = w_filt[uo_pkg::FILT_WIDTH-1] ? uo_pkg::FILT_WIDTH'(-w_filt)
                                                   : uo_pkg::FILT_WIDTH'(w_filt);

        w_peak_wide = w_acc >>> uo_pkg::FRAC_BITS;
        if (w_peak_wide < uo_pkg::ACC_ONE) begin
            w_peak_dec = uo_pkg::PEAK_ONE;
        end else begin
            w_peak_dec = w_peak_wide[uo_pkg::FILT_WIDTH-1:0];
        end
        w_peak_new = (r_mag > w_peak_dec) ? r_mag : w_peak_dec;

        w_filt_last = (r_term == uo_pkg::TERM_LAST) && (r_digit == uo_pkg::DIGIT_LAST);
        w_peak_last = (r_digit == uo_pkg::DIGIT_LAST);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uo_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_idx == '0) ? uo_pkg::S_DIV : uo_pkg::S_FILT_MAC;
                end
            end
            uo_pkg::S_FILT_MAC: begin
                if (w_filt_last) begin
                    n_state = uo_pkg::S_FILT_DRAIN;
                end
            end
            uo_pkg::S_FILT_DRAIN: n_state = uo_pkg::S_FILT_DONE;
            uo_pkg::S_FILT_DONE:  n_state = uo_pkg::S_PEAK_MAC;
            uo_pkg::S_PEAK_MAC: begin
                if (w_peak_last) begin
                    n_state = uo_pkg::S_PEAK_DRAIN;
                end
            end
            uo_pkg::S_PEAK_DRAIN: n_state = uo_pkg::S_PEAK_DONE;
            uo_pkg::S_PEAK_DONE:  n_state = uo_pkg::S_DIV;
            uo_pkg::S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = uo_pkg::S_HOLD;
                end
            end
            uo_pkg::S_HOLD: begin
                if (w_out_load) begin
                    n_state = uo_pkg::S_IDLE;
                end
            end
            default: n_state = uo_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_mac_req       = '0;
        w_div_req       = '0;
        w_out_load      = 1'b0;
        w_mac_req.digit = r_digit;
        unique case (r_state)
            uo_pkg::S_IDLE: begin
                if (w_accept && (w_idx == '0)) begin
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = uo_pkg::PEAK_ONE;
                end
            end
            uo_pkg::S_FILT_MAC: begin
                w_mac_req.issue      = 1'b1;
                w_mac_req.clear      = (r_term == uo_pkg::TERM_INPUT) && (r_digit == '0);
                w_mac_req.round_filt = 1'b1;
                case (r_term)
                    uo_pkg::TERM_INPUT: begin
                        w_mac_req.coef    = r_coef_input;
                        w_mac_req.operand = uo_pkg::OPND_WIDTH'(r_sum);
                    end
                    uo_pkg::TERM_PREV1: begin
                        w_mac_req.coef    = r_coef_prev1;
                        w_mac_req.operand = $signed({r_filt_prev1, 1'b0});
                    end
                    uo_pkg::TERM_PREV2: begin
                        w_mac_req.coef    = r_coef_prev2;
                        w_mac_req.operand = $signed({r_filt_prev2, 1'b0});
                    end
                    default: begin
                        w_mac_req.coef    = '0;
                        w_mac_req.operand = '0;
                    end
                endcase
            end
            uo_pkg::S_PEAK_MAC: begin
                w_mac_req.issue   = 1'b1;
                w_mac_req.clear   = (r_digit == '0);
                w_mac_req.coef    = uo_pkg::DECAY_Q30;
                w_mac_req.operand = $signed({1'b0, r_peak});
            end
            uo_pkg::S_PEAK_DONE: begin
                w_div_req.start    = 1'b1;
                w_div_req.neg      = r_neg;
                w_div_req.dividend = r_mag;
                w_div_req.divisor  = w_peak_new;
            end
            uo_pkg::S_HOLD: begin
                w_out_load = !r_out_valid || o_out.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= uo_pkg::S_IDLE;
            r_coef_input  <= uo_pkg::COEF_INPUT_RST;
            r_coef_prev1  <= uo_pkg::COEF_PREV1_RST;
            r_coef_prev2  <= uo_pkg::COEF_PREV2_RST;
            r_price_prev1 <= '0;
            r_price_prev2 <= '0;
            r_noise_prev  <= '0;
            r_filt_prev1  <= '0;
            r_filt_prev2  <= '0;
            r_peak        <= uo_pkg::PEAK_ONE;
            r_count       <= '0;
            r_term        <= '0;
            r_digit       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (uo_pkg::t_cfg_idx'(i_cfg_index))
                    uo_pkg::CFG_COEF_INPUT: r_coef_input <= i_cfg_data;
                    uo_pkg::CFG_COEF_PREV1: r_coef_prev1 <= i_cfg_data;
                    uo_pkg::CFG_COEF_PREV2: r_coef_prev2 <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_price_prev2 <= r_price_prev1;
                r_price_prev1 <= i_in.price;
                r_noise_prev  <= w_noise;
                r_count       <= (w_idx == uo_pkg::COUNT_MAX) ? uo_pkg::COUNT_MAX
                                                              : w_idx + uo_pkg::COUNT_W'(1);
                r_term        <= '0;
                r_digit       <= '0;
                if (w_idx == '0) begin
                    r_filt_prev1 <= '0;
                    r_filt_prev2 <= '0;
                    r_peak       <= uo_pkg::PEAK_ONE;
                end
            end

            unique case (r_state)
                uo_pkg::S_FILT_MAC: begin
                    if (r_digit == uo_pkg::DIGIT_LAST) begin
                        r_digit <= '0;
                        r_term  <= r_term + uo_pkg::TERM_IDX_W'(1);
                    end else begin
                        r_digit <= r_digit + uo_pkg::DIGIT_IDX_W'(1);
                    end
                end
                uo_pkg::S_FILT_DONE: begin
                    r_filt_prev2 <= r_filt_prev1;
                    r_filt_prev1 <= w_filt;
                    r_digit      <= '0;
                end
                uo_pkg::S_PEAK_MAC: begin
                    if (r_digit == uo_pkg::DIGIT_LAST) begin
                        r_digit <= '0;
                    end else begin
                        r_digit <= r_digit + uo_pkg::DIGIT_IDX_W'(1);
                    end
                end
                uo_pkg::S_PEAK_DONE: begin
                    r_peak <= w_peak_new;
                end
                default: ;
            endcase

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sum <= w_sum;
        end
        if (r_state == uo_pkg::S_FILT_DONE) begin
            r_mag <= w_filt_mag;
            r_neg <= w_filt[uo_pkg::FILT_WIDTH-1];
        end
        if (w_out_load) begin
            r_out_data <= w_div_stat.result;
        end
    end

    `UO_ASSERT_NOW(a_ready_div_idle, i_clk, i_rst_n, w_in_ready, !w_div_stat.busy, "new word taken while divider busy")
    `UO_ASSERT_NOW(a_peak_nonzero, i_clk, i_rst_n, 1'b1, (r_peak != '0), "peak level reached zero")

endmodule
